// ===== rtl/core/kc_pkg.sv =====
`default_nettype none
package kc_pkg;

	localparam int COL_W = 11;
	localparam int ROW_W = 16;
	localparam int POS_W = 27;

	typedef enum logic [1:0] {
		MODE_PIXEL = 2'd0,
		MODE_FLUSH = 2'd1,
		MODE_COEF  = 2'd2
	} kc_mode_t;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_KSIZE  = 2'd2;

	localparam logic [10:0] RST_WIDTH  = 11'd640;
	localparam logic [15:0] RST_HEIGHT = 16'd480;
	localparam logic [2:0]  RST_KSIZE  = 3'd3;

	typedef struct packed {
		logic [COL_W-1:0] w;
		logic [ROW_W-1:0] h;
		logic [2:0]       k;
		logic [1:0]       r;
	} kc_cfg_t;

	typedef struct packed {
		logic                is_coef;
		logic [4:0]          cidx;
		logic signed [15:0]  cval;
		logic [COL_W-1:0]    col;
		logic [7:0]          pix;
		logic                emit;
		logic [COL_W-1:0]    xo;
		logic [ROW_W-1:0]    yo;
		logic                eor;
		logic                eof;
	} kc_item_t;

	function automatic logic [COL_W-1:0] eff_w(input logic [COL_W-1:0] raw, input int maxw);
		logic [COL_W-1:0] w;
		w = raw;
		if (w == '0)
			w = COL_W'(1);
		if (int'(w) > maxw)
			w = COL_W'(maxw);
		return w;
	endfunction

	function automatic logic [ROW_W-1:0] eff_h(input logic [ROW_W-1:0] raw);
		return (raw == '0) ? ROW_W'(1) : raw;
	endfunction

	function automatic logic [2:0] eff_k(input logic [2:0] raw, input int maxk);
		logic [2:0] k;
		int mk;
		mk = 2 * ((maxk - 1) / 2) + 1;
		k = raw;
		if (k == 3'd0)
			k = 3'd1;
		if (k[0] == 1'b0)
			k = k - 3'd1;
		if (int'(k) > mk)
			k = 3'(mk);
		return k;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/kc_queue.sv =====
`default_nettype none
module kc_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire kc_pkg::kc_item_t push_item,
	output logic                  full,
	input  wire logic             pop,
	output logic                  head_valid,
	output kc_pkg::kc_item_t      head_item
);

	kc_pkg::kc_item_t ent_q [2];
	logic             rd_q;
	logic             wr_q;
	logic [1:0]       cnt_q;
	logic             do_pop;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_item  = ent_q[rd_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (do_pop)
				rd_q <= ~rd_q;
			if (push && !do_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (!push && do_pop)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= push_item;
	end

endmodule
`default_nettype wire

// ===== rtl/core/kc_front.sv =====
`default_nettype none
module kc_front #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_KSIZE = 5
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [1:0]   mode,
	input  wire logic [7:0]   pixel_value,
	input  wire logic [4:0]   coef_index,
	input  wire logic [15:0]  coef_value,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [15:0]  cfg_data,
	output kc_pkg::kc_cfg_t   cfg,
	output logic              push,
	output kc_pkg::kc_item_t  item,
	input  wire logic         full
);

	localparam logic [kc_pkg::COL_W-1:0] RW = kc_pkg::eff_w(kc_pkg::RST_WIDTH, MAX_WIDTH);
	localparam logic [kc_pkg::ROW_W-1:0] RH = kc_pkg::eff_h(kc_pkg::RST_HEIGHT);
	localparam logic [2:0] RK = kc_pkg::eff_k(kc_pkg::RST_KSIZE, MAX_KSIZE);
	localparam logic [kc_pkg::POS_W-1:0] RST_DELAY =
		kc_pkg::POS_W'(RK / 3'd2) * kc_pkg::POS_W'(RW) + kc_pkg::POS_W'(RK / 3'd2);
	localparam logic [kc_pkg::POS_W-1:0] RST_TOTAL =
		kc_pkg::POS_W'(RW) * kc_pkg::POS_W'(RH) + RST_DELAY;

	logic [kc_pkg::COL_W-1:0] w_raw_q, w_raw_d, nw;
	logic [kc_pkg::ROW_W-1:0] h_raw_q, h_raw_d, nh;
	logic [2:0]               k_raw_q, k_raw_d, nk;
	logic [kc_pkg::POS_W-1:0] delay_q, total_q, delay_d;

	logic [kc_pkg::POS_W-1:0]   p_q;
	logic [kc_pkg::COL_W-1:0]   col_q, xo_q;
	logic [kc_pkg::ROW_W:0]     row_q;
	logic [kc_pkg::ROW_W-1:0]   yo_q;

	logic accept, stream, emit, wrap_end, cfg_hit;
	kc_pkg::kc_mode_t md;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;
	assign md       = kc_pkg::kc_mode_t'(mode);

	always_comb begin
		w_raw_d = w_raw_q;
		h_raw_d = h_raw_q;
		k_raw_d = k_raw_q;
		cfg_hit = 1'b0;
		if (cfg_we) begin
			unique case (cfg_index)
				kc_pkg::CFG_WIDTH: begin
					w_raw_d = cfg_data[kc_pkg::COL_W-1:0];
					cfg_hit = 1'b1;
				end
				kc_pkg::CFG_HEIGHT: begin
					h_raw_d = cfg_data;
					cfg_hit = 1'b1;
				end
				kc_pkg::CFG_KSIZE: begin
					k_raw_d = cfg_data[2:0];
					cfg_hit = 1'b1;
				end
				default: cfg_hit = 1'b0;
			endcase
		end
		nw = kc_pkg::eff_w(w_raw_d, MAX_WIDTH);
		nh = kc_pkg::eff_h(h_raw_d);
		nk = kc_pkg::eff_k(k_raw_d, MAX_KSIZE);
		delay_d = kc_pkg::POS_W'(nk / 3'd2) * kc_pkg::POS_W'(nw) + kc_pkg::POS_W'(nk / 3'd2);
	end

	always_comb begin
		cfg.w = kc_pkg::eff_w(w_raw_q, MAX_WIDTH);
		cfg.h = kc_pkg::eff_h(h_raw_q);
		cfg.k = kc_pkg::eff_k(k_raw_q, MAX_KSIZE);
		cfg.r = 2'(cfg.k / 3'd2);
	end

	always_comb begin
		stream = 1'b0;
		unique case (md)
			kc_pkg::MODE_PIXEL: stream = 1'b1;
			kc_pkg::MODE_FLUSH: stream = 1'b1;
			kc_pkg::MODE_COEF:  stream = 1'b0;
			default:            stream = 1'b0;
		endcase
	end

	assign emit     = (p_q >= delay_q);
	assign wrap_end = ((p_q + kc_pkg::POS_W'(1)) >= total_q);
	assign push     = accept && (stream || (md == kc_pkg::MODE_COEF));

	always_comb begin
		item.is_coef = !stream;
		item.cidx    = coef_index;
		item.cval    = $signed(coef_value);
		item.col     = col_q;
		item.pix     = (md == kc_pkg::MODE_PIXEL && row_q < {1'b0, cfg.h}) ? pixel_value : 8'd0;
		item.emit    = emit;
		item.xo      = xo_q;
		item.yo      = yo_q;
		item.eor     = (xo_q == cfg.w - kc_pkg::COL_W'(1));
		item.eof     = item.eor && (yo_q == cfg.h - kc_pkg::ROW_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_raw_q <= kc_pkg::RST_WIDTH;
			h_raw_q <= kc_pkg::RST_HEIGHT;
			k_raw_q <= kc_pkg::RST_KSIZE;
			delay_q <= RST_DELAY;
			total_q <= RST_TOTAL;
		end else begin
			w_raw_q <= w_raw_d;
			h_raw_q <= h_raw_d;
			k_raw_q <= k_raw_d;
			delay_q <= delay_d;
			total_q <= kc_pkg::POS_W'(nw) * kc_pkg::POS_W'(nh) + delay_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q   <= '0;
			col_q <= '0;
			row_q <= '0;
			xo_q  <= '0;
			yo_q  <= '0;
		end else if (cfg_hit) begin
			p_q   <= '0;
			col_q <= '0;
			row_q <= '0;
			xo_q  <= '0;
			yo_q  <= '0;
		end else if (accept && stream) begin
			if (wrap_end) begin
				p_q   <= '0;
				col_q <= '0;
				row_q <= '0;
				xo_q  <= '0;
				yo_q  <= '0;
			end else begin
				p_q <= p_q + kc_pkg::POS_W'(1);
				if (col_q == cfg.w - kc_pkg::COL_W'(1)) begin
					col_q <= '0;
					row_q <= row_q + 17'd1;
				end else begin
					col_q <= col_q + kc_pkg::COL_W'(1);
				end
				if (emit) begin
					if (item.eor) begin
						xo_q <= '0;
						yo_q <= yo_q + kc_pkg::ROW_W'(1);
					end else begin
						xo_q <= xo_q + kc_pkg::COL_W'(1);
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/kc_back.sv =====
`default_nettype none
module kc_back #(
	parameter int MAX_WIDTH      = 1024,
	parameter int MAX_KSIZE      = 5,
	parameter int COEF_FRAC_BITS = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire kc_pkg::kc_cfg_t  cfg,
	input  wire logic             q_valid,
	input  wire kc_pkg::kc_item_t q_item,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [7:0]            out_pixel,
	output logic                  end_of_row,
	output logic                  end_of_frame
);

	localparam int MR  = (MAX_KSIZE - 1) / 2;
	localparam int MK  = 2 * MR + 1;
	localparam int LBR = (MR > 0) ? 2 * MR : 1;
	localparam int LBW = 8 * LBR;
	localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int NC  = MAX_KSIZE * MAX_KSIZE;
	localparam int CIW = (NC > 1) ? $clog2(NC) : 1;
	localparam int PSW = 25;
	localparam int RSW = PSW + ((MK > 1) ? $clog2(MK) : 0);
	localparam int TSW = RSW + ((MK > 1) ? $clog2(MK) : 0);

	logic en;

	// line buffer: byte i-1 of a word holds the column i rows above
	logic [LBW-1:0] mem [MAX_WIDTH];
	logic [LBW-1:0] rd_s1, wword;
	logic [AW-1:0]  raddr, waddr;
	logic           we;

	logic             v_s1, v_s2, v_s3, v_s4, v_s5;
	kc_pkg::kc_item_t it_s1, it_s2;
	logic             eor_s3, eor_s4, eor_s5, eof_s3, eof_s4, eof_s5;

	logic [7:0]               colvec [MK];
	logic [7:0]               win_q [MK][MK];
	logic signed [15:0]       coef_q [NC];
	logic signed [15:0]       weight_q [MK][MK];
	logic [CIW-1:0]           widx [MK][MK];
	logic                     wok [MK][MK];
	logic                     rv [MK];
	logic                     cv [MK];
	logic signed [PSW-1:0]    prod_s3 [MK][MK];
	logic signed [RSW-1:0]    rsum_s4 [MK];
	logic signed [RSW-1:0]    rsum_d [MK];
	logic signed [TSW-1:0]    sum_s5, sum_d;
	logic signed [TSW-1:0]    shifted;
	logic [7:0]               clamp_d;

	assign en    = !m_tvalid || m_tready;
	assign q_pop = en && q_valid;

	assign raddr = AW'(q_item.col);
	assign waddr = AW'(it_s1.col);
	assign we    = en && v_s1 && !it_s1.is_coef;

	always_comb begin
		wword[7:0] = it_s1.pix;
		for (int k = 1; k < LBR; k++)
			wword[8*k +: 8] = rd_s1[8*(k-1) +: 8];
		colvec[0] = it_s1.pix;
		for (int i = 1; i < MK; i++)
			colvec[i] = rd_s1[8*(i-1) +: 8];
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wword;
		if (en)
			rd_s1 <= (we && waddr == raddr) ? wword : mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && !it_s2.is_coef && it_s2.emit;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			m_tvalid <= v_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < NC; n++)
				coef_q[n] <= '0;
		end else if (en && v_s1 && it_s1.is_coef && int'(it_s1.cidx) < NC) begin
			coef_q[CIW'(it_s1.cidx)] <= it_s1.cval;
		end
	end

	always_comb begin
		int a;
		int b;
		int idx;
		for (int i = 0; i < MK; i++) begin
			for (int j = 0; j < MK; j++) begin
				a = 2 * int'(cfg.r) - i;
				b = 2 * int'(cfg.r) - j;
				wok[i][j] = (a >= 0) && (b >= 0);
				idx = wok[i][j] ? (a * int'(cfg.k) + b) : 0;
				widx[i][j] = CIW'(idx);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MK; i++)
			for (int j = 0; j < MK; j++)
				weight_q[i][j] <= wok[i][j] ? coef_q[widx[i][j]] : 16'sd0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= q_item;
			it_s2 <= it_s1;
			if (v_s1 && !it_s1.is_coef) begin
				for (int i = 0; i < MK; i++) begin
					win_q[i][0] <= colvec[i];
					for (int j = 1; j < MK; j++)
						win_q[i][j] <= win_q[i][j-1];
				end
			end
		end
	end

	// slot (i,j) holds the pixel i rows above and j columns left of the newest one
	always_comb begin
		int t;
		for (int i = 0; i < MK; i++) begin
			t = int'(it_s2.yo) + int'(cfg.r) - i;
			rv[i] = (t >= 0) && (t < int'(cfg.h));
			t = int'(it_s2.xo) + int'(cfg.r) - i;
			cv[i] = (t >= 0) && (t < int'(cfg.w));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < MK; i++)
				for (int j = 0; j < MK; j++)
					prod_s3[i][j] <= $signed({1'b0, ((rv[i] && cv[j]) ? win_q[i][j] : 8'd0)})
						* weight_q[i][j];
			eor_s3 <= it_s2.eor;
			eof_s3 <= it_s2.eof;
		end
	end

	always_comb begin
		for (int i = 0; i < MK; i++) begin
			rsum_d[i] = '0;
			for (int j = 0; j < MK; j++)
				rsum_d[i] = rsum_d[i] + RSW'(prod_s3[i][j]);
		end
		sum_d = '0;
		for (int i = 0; i < MK; i++)
			sum_d = sum_d + TSW'(rsum_s4[i]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsum_s4 <= rsum_d;
			eor_s4  <= eor_s3;
			eof_s4  <= eof_s3;
			sum_s5  <= sum_d;
			eor_s5  <= eor_s4;
			eof_s5  <= eof_s4;
		end
	end

	always_comb begin
		shifted = sum_s5 >>> COEF_FRAC_BITS;
		if (sum_s5 < 0)
			clamp_d = 8'd0;
		else if (shifted > TSW'(255))
			clamp_d = 8'd255;
		else
			clamp_d = shifted[7:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_pixel    <= clamp_d;
			end_of_row   <= eor_s5;
			end_of_frame <= eof_s5;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/kernel_convolution.sv =====
// Pixel and flush words run through s1 to s5 and the output register; s1 writes the line buffer.
// Throughput: one word per cycle unless stalled; the line buffer takes one read per word.
// Outputs trail the stream by R rows plus R pixels (R = kernel_size / 2); flush words drain them.
// Reset: position counters cleared, coefficients zero, registers 640 x 480 with a 3x3 kernel.
// The line buffer is not cleared; rows not yet written this frame are masked as zero.
`default_nettype none
module kernel_convolution #(
	parameter int MAX_WIDTH      = 1024,
	parameter int MAX_KSIZE      = 5,
	parameter int COEF_FRAC_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // pixel_value[7:0], coef_index[12:8], coef_value[28:13]
	input  wire logic [1:0]  s_tuser,   // mode[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // out_pixel[7:0]
	output logic             m_tlast,
	output logic             m_tuser,   // end_of_frame
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	kc_pkg::kc_cfg_t  cfg;
	kc_pkg::kc_item_t f_item, q_head;
	logic             f_push, q_full, q_valid, q_pop;

	kc_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_KSIZE(MAX_KSIZE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.mode(s_tuser),
		.pixel_value(s_tdata[7:0]),
		.coef_index(s_tdata[12:8]),
		.coef_value(s_tdata[28:13]),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg),
		.push(f_push),
		.item(f_item),
		.full(q_full)
	);

	kc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(f_push),
		.push_item(f_item),
		.full(q_full),
		.pop(q_pop),
		.head_valid(q_valid),
		.head_item(q_head)
	);

	kc_back #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_KSIZE(MAX_KSIZE),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.q_valid(q_valid),
		.q_item(q_head),
		.q_pop(q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.out_pixel(m_tdata),
		.end_of_row(m_tlast),
		.end_of_frame(m_tuser)
	);

endmodule
`default_nettype wire

// ===== tb/tb_kernel_convolution.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_kernel_convolution;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [1:0] CFG_NONE    = 2'd3;
	localparam int RING   = 7;
	localparam int MAXW   = 1024;
	localparam int NCOEF  = 25;
	localparam int N_ITEMS = 1850;

	typedef struct {
		logic [7:0] pix;
		logic       eor;
		logic       eof;
	} conv_out_t;

	class conv_scoreboard;
		logic [10:0] wreg;
		logic [15:0] hreg;
		logic [2:0]  kreg;
		logic [7:0]  lines [RING][MAXW];
		int          coef [NCOEF];
		int          row_i, col_i;
		int          errors;
		conv_out_t   q [$];

		function new();
			wreg = kc_pkg::RST_WIDTH;
			hreg = kc_pkg::RST_HEIGHT;
			kreg = kc_pkg::RST_KSIZE;
			foreach (lines[i, j]) lines[i][j] = '0;
			foreach (coef[i]) coef[i] = 0;
			row_i = 0;
			col_i = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] v);
			if (idx == kc_pkg::CFG_WIDTH) wreg = v[10:0];
			else if (idx == kc_pkg::CFG_HEIGHT) hreg = v;
			else if (idx == kc_pkg::CFG_KSIZE) kreg = v[2:0];
			else return;
			row_i = 0;
			col_i = 0;
		endfunction

		function void note_word(logic [1:0] mode, logic [7:0] pix, logic [4:0] ci,
				logic signed [15:0] cv);
			longint w, h, k, r, delay, total, pos, o, yo, xo, sum, rr, cc;
			int pv;
			conv_out_t e;
			if (mode == kc_pkg::MODE_COEF) begin
				if (ci < NCOEF) coef[ci] = cv;
				return;
			end
			if (mode == MODE_UNUSED) return;
			w = wreg;
			if (w == 0) w = 1;
			if (w > MAXW) w = MAXW;
			h = (hreg == 0) ? 1 : hreg;
			k = kreg;
			if (k == 0) k = 1;
			if (k % 2 == 0) k = k - 1;
			if (k > 5) k = 5;
			r = k / 2;
			delay = r * w + r;
			total = w * h + delay;
			if (col_i >= w) begin
				col_i = 0;
				row_i = 0;
			end
			if (row_i < h)
				lines[row_i % RING][col_i] = (mode == kc_pkg::MODE_PIXEL) ? pix : 8'd0;
			pos = longint'(row_i) * w + col_i;
			if (pos >= delay && pos - delay < w * h) begin
				o = pos - delay;
				yo = o / w;
				xo = o % w;
				sum = 0;
				for (int a = 0; a < k; a++)
					for (int b = 0; b < k; b++) begin
						rr = yo + a - r;
						cc = xo + b - r;
						pv = 0;
						if (rr >= 0 && cc >= 0 && rr < h && cc < w) pv = lines[rr % RING][cc];
						sum += longint'(pv) * coef[a * k + b];
					end
				if (sum < 0) e.pix = 0;
				else if ((sum >>> 8) > 255) e.pix = 8'd255;
				else e.pix = 8'(sum >>> 8);
				e.eor = (xo == w - 1);
				e.eof = (o == w * h - 1);
				q.insert(q.size(), e);
			end
			col_i++;
			if (col_i >= w) begin
				col_i = 0;
				row_i++;
			end
			if (longint'(row_i) * w + col_i >= total) begin
				row_i = 0;
				col_i = 0;
			end
		endfunction

		function void check_word(logic [7:0] pix, logic eor, logic eof);
			conv_out_t e;
			if (q.size() == 0) begin
				$error("unexpected output word pix=%0d", pix);
				errors++;
				return;
			end
			e = q.pop_front();
			if (pix !== e.pix) begin
				$error("out_pixel exp %0d got %0d", e.pix, pix);
				errors++;
			end
			if (eor !== e.eor) begin
				$error("end_of_row exp %0d got %0d", e.eor, eor);
				errors++;
			end
			if (eof !== e.eof) begin
				$error("end_of_frame exp %0d got %0d", e.eof, eof);
				errors++;
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        s_tvalid, s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid, m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast, m_tuser;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	conv_scoreboard sb;
	int sent, got;
	int cur_w, cur_h, cur_k;

	kernel_convolution dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("tb_kernel_convolution: FAIL");
		$finish;
	end

	task automatic send_word(logic [1:0] mode, logic [7:0] pix, logic [4:0] ci,
			logic [15:0] cv);
		if (!(sent >= 700 && sent < 1000) && $urandom_range(0, 99) < 13) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {3'b0, cv, ci, pix};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_word(mode, pix, ci, cv);
		if (mode != MODE_UNUSED) sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	function automatic int eff(int v, int lo, int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	task automatic configure(logic [15:0] w, logic [15:0] h, logic [15:0] k);
		int kk;
		wait_idle();
		if ($urandom_range(0, 3) == 0) write_reg(CFG_NONE, 16'($urandom));
		write_reg(kc_pkg::CFG_KSIZE, k);
		write_reg(kc_pkg::CFG_WIDTH, w);
		write_reg(kc_pkg::CFG_HEIGHT, h);
		cfg_we <= 1'b0;
		cur_w = eff(int'(w[10:0]), 1, MAXW);
		cur_h = eff(int'(h), 1, 65535);
		kk = (k[2:0] == 0) ? 1 : int'(k[2:0]);
		if (kk % 2 == 0) kk--;
		cur_k = (kk > 5) ? 5 : kk;
	endtask

	task automatic load_coefs();
		int full;
		full = ($urandom_range(0, 9) == 0);
		for (int i = 0; i < NCOEF; i++)
			send_word(kc_pkg::MODE_COEF, 8'($urandom), 5'(i),
				full ? 16'($urandom) : 16'($urandom_range(0, 600) - 300));
	endtask

	task automatic stream_frame();
		int area, delay, n, pick;
		delay = (cur_k / 2) * cur_w + cur_k / 2;
		area = cur_w * cur_h;
		n = area + delay;
		if (n > 300) n = $urandom_range(20, 300);
		else n += $urandom_range(0, 3);
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 2)
				send_word(MODE_UNUSED, 8'($urandom), 5'($urandom), 16'($urandom));
			else if (pick < 4)
				send_word(kc_pkg::MODE_COEF, 8'($urandom), 5'($urandom),
					16'($urandom_range(0, 512) - 256));
			else if (i >= area ? pick < 80 : pick < 12)
				send_word(kc_pkg::MODE_FLUSH, 8'($urandom), 5'($urandom), 16'($urandom));
			else
				send_word(kc_pkg::MODE_PIXEL, 8'($urandom), 5'($urandom), 16'($urandom));
		end
	endtask

	// receiver: random stalls, one long hold to back up the pipe
	initial begin
		int hold;
		hold = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				sb.check_word(m_tdata, m_tlast, m_tuser);
				got++;
			end
			if (got >= 150 && hold == 0 && s_tvalid) hold = 400;
			if (hold > 1) begin
				hold--;
				m_tready <= 1'b0;
			end else if (got >= 500 && got < 800)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 99) >= 13);
		end
	end

	initial begin
		int ws [$];
		int hs [$];
		logic [15:0] w, h, k;
		ws = '{16'd0, 16'd1, 16'd1024, 16'hFFFF, 16'd700};
		hs = '{16'd0, 16'd1, 16'hFFFF};
		sb = new();
		sent = 0;
		got = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = kc_pkg::MODE_PIXEL;
		cfg_we = 1'b0;
		cfg_index = kc_pkg::CFG_WIDTH;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme coefficients, ignored slots, unused mode, edge pixels
		configure(16'd3, 16'd2, 16'd3);
		send_word(kc_pkg::MODE_COEF, 8'd0, 5'd0, 16'h8000);
		send_word(kc_pkg::MODE_COEF, 8'd0, 5'd24, 16'h7FFF);
		send_word(kc_pkg::MODE_COEF, 8'd0, 5'd25, 16'h0100);
		send_word(kc_pkg::MODE_COEF, 8'd0, 5'd31, 16'h0100);
		send_word(kc_pkg::MODE_COEF, 8'd0, 5'd4, 16'h0100);
		send_word(MODE_UNUSED, 8'hFF, 5'd4, 16'h0100);
		send_word(kc_pkg::MODE_PIXEL, 8'd255, 5'd0, 16'd0);
		send_word(kc_pkg::MODE_PIXEL, 8'd0, 5'd0, 16'd0);
		send_word(kc_pkg::MODE_PIXEL, 8'd255, 5'd0, 16'd0);
		send_word(kc_pkg::MODE_FLUSH, 8'd255, 5'd0, 16'd0);
		send_word(kc_pkg::MODE_PIXEL, 8'd128, 5'd0, 16'd0);
		send_word(kc_pkg::MODE_PIXEL, 8'd1, 5'd0, 16'd0);
		for (int i = 0; i < 6; i++) send_word(kc_pkg::MODE_FLUSH, 8'd0, 5'd0, 16'd0);

		while (sent < N_ITEMS) begin
			k = 16'($urandom);
			if ($urandom_range(0, 9) == 0) begin
				w = 16'(ws[$urandom_range(0, ws.size() - 1)]);
				h = 16'($urandom_range(1, 4));
			end else if ($urandom_range(0, 9) == 0) begin
				w = 16'($urandom_range(1, 4));
				h = 16'(hs[$urandom_range(0, hs.size() - 1)]);
			end else begin
				w = {5'($urandom), 11'($urandom_range(1, 10))};
				h = 16'($urandom_range(1, 7));
			end
			configure(w, h, k);
			if ($urandom_range(0, 2) != 0) load_coefs();
			stream_frame();
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		for (int i = 0; i < 200000 && sb.q.size() != 0; i++) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.q.size() != 0) begin
			$error("%0d expected words never arrived", sb.q.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("tb_kernel_convolution: PASS");
		else
			$display("tb_kernel_convolution: FAIL");
		$finish;
	end

endmodule
`default_nettype wire
